>>> hdl/dcfr_pkg.sv
package dcfr_pkg;

  // Frame geometry and marker bytes.
  localparam int          FRAME_LENGTH = 8;
  localparam logic [7:0]  START_MARK   = 8'h2A;
  localparam logic [7:0]  END_MARK     = 8'h23;
  localparam logic [2:0]  CLOSE_POS    = 3'd7;
  localparam logic [7:0]  FLAG_SET     = 8'd1;

  // Step codes carried in byte 1.
  localparam logic [7:0]  INCREMENT    = 8'd1;
  localparam logic [7:0]  DECREMENT    = 8'd2;

  // One classified byte, handed from the framer to the command stage.
  typedef struct packed {
    logic        close_ok;
    logic [7:0]  step_code;
    logic [15:0] rpm;
    logic [7:0]  window;
    logic        window_flag;
    logic        rpm_flag;
  } frame_item_t;

  // One result item, as delivered on the result ports.
  typedef struct packed {
    logic        frame_done;
    logic        increment_pulse;
    logic        decrement_pulse;
    logic        step_ready;
    logic        rpm_write;
    logic [15:0] rpm_value;
    logic        window_write;
    logic [7:0]  window_value;
  } result_t;

endpackage

>>> hdl/delimited_command_frame_receiver_top.sv
// Path: an accepted byte is classified into the byte queue, then executed into the result queue.
// Throughput: one byte per cycle while the result queue has room to take each executed item.
// A stalled result side fills the result queue, then the byte queue, then raises full.
// Reset: rst_n is synchronous, active low; it empties both queues, returns the framer to
// hunting for the start byte, clears the stored step code, rpm and window, and sets ready.
module delimited_command_frame_receiver_top #(
  parameter int QUEUE_DEPTH  = 2,
  parameter int RESULT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic        out_frame_done,
  output logic        out_increment_pulse,
  output logic        out_decrement_pulse,
  output logic        out_step_ready,
  output logic        out_rpm_write,
  output logic [15:0] out_rpm_value,
  output logic        out_window_write,
  output logic [7:0]  out_window_value
);

  import dcfr_pkg::*;

  localparam int IW = $bits(frame_item_t);
  localparam int RW = $bits(result_t);

  frame_item_t front_item, back_item;
  result_t     back_res, out_res;
  logic [IW-1:0] mid_rdata;
  logic [RW-1:0] res_rdata;
  logic        accept;
  logic        mid_empty, res_full, go;

  // Front side: classify each accepted byte into the byte queue.
  assign accept = push && !full;

  dcfr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .item    (front_item)
  );

  dcfr_fifo #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (front_item),
    .full  (full),
    .pop   (go),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  // Back side: execute one queued item whenever the result queue has room.
  assign back_item = frame_item_t'(mid_rdata);
  assign go        = !mid_empty && !res_full;

  dcfr_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (back_item),
    .res   (back_res)
  );

  dcfr_fifo #(.WIDTH(RW), .DEPTH(RESULT_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (go),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  // Result ports.
  assign out_res             = result_t'(res_rdata);
  assign out_frame_done      = out_res.frame_done;
  assign out_increment_pulse = out_res.increment_pulse;
  assign out_decrement_pulse = out_res.decrement_pulse;
  assign out_step_ready      = out_res.step_ready;
  assign out_rpm_write       = out_res.rpm_write;
  assign out_rpm_value       = out_res.rpm_value;
  assign out_window_write    = out_res.window_write;
  assign out_window_value    = out_res.window_value;

endmodule

>>> hdl/dcfr_fifo.sv
module dcfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  // Handshake qualification.
  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> hdl/dcfr_front.sv
module dcfr_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            rx_byte,
  output dcfr_pkg::frame_item_t item
);

  import dcfr_pkg::*;

  typedef enum logic {HUNT, READ} frame_state_t;

  frame_state_t state_r, state_nxt;
  logic [2:0]   pos_r, pos_nxt;
  logic [7:0]   frame_r [FRAME_LENGTH];
  logic         store_byte;

  // Hunting and position tracking for each accepted byte.
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    store_byte = 1'b0;
    if (accept) begin
      if (state_r == HUNT) begin
        if (rx_byte == START_MARK) begin
          state_nxt = READ;
          pos_nxt   = 3'd1;
        end else begin
          pos_nxt = 3'd0;
        end
      end else if (pos_r == CLOSE_POS) begin
        state_nxt = HUNT;
        pos_nxt   = 3'd0;
      end else begin
        store_byte = 1'b1;
        pos_nxt    = pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HUNT;
      pos_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Frame body bytes; the closing byte is checked on arrival and not stored.
  always_ff @(posedge clk) begin
    if (store_byte) begin
      frame_r[pos_r] <= rx_byte;
    end
  end

  // Classify the byte: only a good closing byte carries a frame onward.
  always_comb begin
    item.close_ok    = (state_r == READ) && (pos_r == CLOSE_POS) && (rx_byte == END_MARK);
    item.step_code   = frame_r[1];
    item.rpm         = {frame_r[3], frame_r[2]};
    item.window      = frame_r[4];
    item.window_flag = (frame_r[5] == FLAG_SET);
    item.rpm_flag    = (frame_r[6] == FLAG_SET);
  end

endmodule

>>> hdl/dcfr_back.sv
module dcfr_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  dcfr_pkg::frame_item_t item,
  output dcfr_pkg::result_t     res
);

  import dcfr_pkg::*;

  logic [7:0]  last_code_r, last_code_nxt;
  logic [15:0] last_rpm_r, last_rpm_nxt;
  logic [7:0]  last_win_r, last_win_nxt;
  logic        ready_r, ready_nxt;

  // Change detection against the last accepted commands.
  always_comb begin
    last_code_nxt = last_code_r;
    last_rpm_nxt  = last_rpm_r;
    last_win_nxt  = last_win_r;
    ready_nxt     = ready_r;
    res           = '0;
    if (item.close_ok) begin
      res.frame_done = 1'b1;
      if (item.step_code != last_code_r) begin
        last_code_nxt = item.step_code;
        if (item.step_code == INCREMENT) begin
          res.increment_pulse = 1'b1;
          ready_nxt           = 1'b0;
        end else if (item.step_code == DECREMENT) begin
          res.decrement_pulse = 1'b1;
          ready_nxt           = 1'b0;
        end else begin
          ready_nxt = 1'b1;
        end
      end
      if (item.rpm_flag && (item.rpm != last_rpm_r)) begin
        last_rpm_nxt  = item.rpm;
        res.rpm_write = 1'b1;
        res.rpm_value = item.rpm;
      end
      if (item.window_flag && (item.window != last_win_r)) begin
        last_win_nxt     = item.window;
        res.window_write = 1'b1;
        res.window_value = item.window;
      end
    end
    res.step_ready = ready_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_code_r <= 8'd0;
      last_rpm_r  <= 16'd0;
      last_win_r  <= 8'd0;
      ready_r     <= 1'b1;
    end else if (go) begin
      last_code_r <= last_code_nxt;
      last_rpm_r  <= last_rpm_nxt;
      last_win_r  <= last_win_nxt;
      ready_r     <= ready_nxt;
    end
  end

`ifndef SYNTH
  // A counter pulse always clears the ready flag for the following items.
  a_pulse_clears_ready: assert property (@(posedge clk) disable iff (!rst_n)
    go && (res.increment_pulse || res.decrement_pulse) |=> !ready_r)
    else $error("ready flag not cleared after a counter pulse");

  // Any command output comes only from a closed, valid frame.
  a_cmd_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    go && (res.increment_pulse || res.decrement_pulse || res.rpm_write ||
           res.window_write) |-> res.frame_done)
    else $error("command issued without a valid frame");

  // An issued rpm set-point becomes the stored reference.
  a_rpm_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    go && res.rpm_write |=> (last_rpm_r == $past(res.rpm_value)))
    else $error("rpm reference not updated");
`endif

endmodule
